// ===== sv/flpa_pkg.sv =====
`timescale 1ns / 1ps
package flpa_pkg;

  localparam int unsigned POOL_DEPTH = 1024;
  localparam int unsigned IDX_W      = $clog2(POOL_DEPTH);
  localparam int unsigned SLOT_W     = $clog2(POOL_DEPTH + 1);
  localparam int unsigned OFF_W      = 20;
  localparam int unsigned SIZE_W     = 11;
  localparam int unsigned USED_W     = 11;
  localparam int unsigned TOTAL_W    = 32;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned CNT_W      = $clog2(OFF_W);
  localparam int unsigned ADDR_W     = 3;
  localparam int unsigned DATA_W     = 32;

  localparam logic [SIZE_W-1:0] SIZE_MIN   = SIZE_W'(8);
  localparam logic [SIZE_W-1:0] SIZE_MAX   = SIZE_W'(1024);
  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(16);
  localparam logic [USED_W-1:0] USED_MAX   = {USED_W{1'b1}};

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_REJECTED  = 2'd2;

  localparam logic REG_ELEMENT_BYTES = 1'b0;

  typedef enum logic [1:0] {
    CMD_ALLOC,
    CMD_FREE,
    CMD_REJECT
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e        kind;
    logic [IDX_W-1:0] slot;
  } cmd_t;

  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] raw);
    logic [SIZE_W-1:0] res;
    res = raw;
    if (raw < SIZE_MIN) begin
      res = SIZE_MIN;
    end else if (raw > SIZE_MAX) begin
      res = SIZE_MAX;
    end
    return res;
  endfunction

endpackage

// ===== sv/flpa_front.sv =====
`timescale 1ns / 1ps
module flpa_front
  import flpa_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic              op_i,
  input  logic [OFF_W-1:0]  offset_i,
  input  logic [SIZE_W-1:0] size_i,
  input  logic              full_i,
  output logic              push_o,
  output cmd_t              cmd_o,
  output logic              idle_o
);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_DIV  = 2'd1;
  localparam logic [1:0] F_PUSH = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [SIZE_W-1:0] rem_q, rem_d;
  logic [OFF_W-1:0]  quo_q, quo_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  cmd_t              cmd_q, cmd_d;
  logic [SIZE_W:0]   trial;
  logic              ge;

  assign trial  = {rem_q, quo_q[OFF_W-1]};
  assign ge     = trial >= {1'b0, size_i};
  assign idle_o = (state_q == F_IDLE);
  assign cmd_o  = cmd_q;

  always_comb begin
    state_d = state_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    cnt_d   = cnt_q;
    cmd_d   = cmd_q;
    push_o  = 1'b0;
    unique case (state_q)
      F_IDLE: begin
        if (accept_i) begin
          if (op_i == OP_FREE) begin
            rem_d   = '0;
            quo_d   = offset_i;
            cnt_d   = CNT_W'(OFF_W - 1);
            state_d = F_DIV;
          end else begin
            cmd_d   = '{kind: CMD_ALLOC, slot: '0};
            state_d = F_PUSH;
          end
        end
      end
      F_DIV: begin
        rem_d = ge ? SIZE_W'(trial - {1'b0, size_i}) : SIZE_W'(trial);
        quo_d = {quo_q[OFF_W-2:0], ge};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          if (rem_d != '0 || quo_d >= OFF_W'(POOL_DEPTH)) begin
            cmd_d = '{kind: CMD_REJECT, slot: '0};
          end else begin
            cmd_d = '{kind: CMD_FREE, slot: quo_d[IDX_W-1:0]};
          end
          state_d = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!full_i) begin
          push_o  = 1'b1;
          state_d = F_IDLE;
        end
      end
      default: begin
        state_d = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    cnt_q <= cnt_d;
    cmd_q <= cmd_d;
  end

endmodule

// ===== sv/flpa_cmd_fifo.sv =====
`timescale 1ns / 1ps
module flpa_cmd_fifo
  import flpa_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  input  logic pop_i,
  output cmd_t cmd_o,
  output logic full_o,
  output logic empty_o
);

  cmd_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       do_push, do_pop;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 2'd1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// ===== sv/flpa_back.sv =====
`timescale 1ns / 1ps
module flpa_back
  import flpa_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [SIZE_W-1:0]   size_i,
  input  logic                empty_i,
  input  cmd_t                cmd_i,
  output logic                pop_o,
  output logic                clearing_o,
  output logic                done_o,
  output logic [STATUS_W-1:0] status_o,
  output logic [OFF_W-1:0]    granted_offset_o,
  output logic [USED_W-1:0]   in_use_o,
  output logic [USED_W-1:0]   peak_in_use_o,
  output logic [TOTAL_W-1:0]  alloc_total_o,
  output logic                full_res_o
);

  localparam logic [1:0] B_CLEAR = 2'd0;
  localparam logic [1:0] B_IDLE  = 2'd1;
  localparam logic [1:0] B_READ  = 2'd2;

  logic [SLOT_W-1:0]   next_mem [POOL_DEPTH];
  logic [SLOT_W-1:0]   rd_q;

  logic [1:0]          state_q, state_d;
  logic [IDX_W-1:0]    clr_q, clr_d;
  logic [IDX_W-1:0]    slot_q, slot_d;
  logic [SLOT_W-1:0]   head_q, head_d;
  logic [USED_W-1:0]   used_q, used_d;
  logic [USED_W-1:0]   peak_q, peak_d;
  logic [TOTAL_W-1:0]  total_q, total_d;

  logic                we;
  logic [IDX_W-1:0]    waddr;
  logic [SLOT_W-1:0]   wdata;
  logic                emit;
  logic [STATUS_W-1:0] status;
  logic [OFF_W-1:0]    granted;

  logic                done_q;
  logic [STATUS_W-1:0] status_q;
  logic [OFF_W-1:0]    granted_q;
  logic [USED_W-1:0]   in_use_q;
  logic [USED_W-1:0]   peak_out_q;
  logic [TOTAL_W-1:0]  total_out_q;
  logic                full_q;

  assign clearing_o       = (state_q == B_CLEAR);
  assign done_o           = done_q;
  assign status_o         = status_q;
  assign granted_offset_o = granted_q;
  assign in_use_o         = in_use_q;
  assign peak_in_use_o    = peak_out_q;
  assign alloc_total_o    = total_out_q;
  assign full_res_o       = full_q;

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    slot_d  = slot_q;
    head_d  = head_q;
    used_d  = used_q;
    total_d = total_q;
    we      = 1'b0;
    waddr   = clr_q;
    wdata   = SLOT_W'(clr_q) + SLOT_W'(1);
    emit    = 1'b0;
    status  = ST_OK;
    granted = '0;
    pop_o   = 1'b0;
    unique case (state_q)
      B_CLEAR: begin
        we    = 1'b1;
        clr_d = clr_q + 1'b1;
        if (clr_q == IDX_W'(POOL_DEPTH - 1)) begin
          state_d = B_IDLE;
        end
      end
      B_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          unique case (cmd_i.kind)
            CMD_ALLOC: begin
              if (head_q >= SLOT_W'(POOL_DEPTH)) begin
                emit   = 1'b1;
                status = ST_EXHAUSTED;
              end else begin
                slot_d  = head_q[IDX_W-1:0];
                state_d = B_READ;
              end
            end
            CMD_FREE: begin
              we     = 1'b1;
              waddr  = cmd_i.slot;
              wdata  = head_q;
              head_d = SLOT_W'(cmd_i.slot);
              used_d = (used_q == '0) ? '0 : used_q - 1'b1;
              emit   = 1'b1;
            end
            default: begin
              emit   = 1'b1;
              status = ST_REJECTED;
            end
          endcase
        end
      end
      B_READ: begin
        head_d  = rd_q;
        used_d  = (used_q == USED_MAX) ? used_q : used_q + 1'b1;
        total_d = total_q + 1'b1;
        granted = OFF_W'(slot_q * size_i);
        emit    = 1'b1;
        state_d = B_IDLE;
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
    peak_d = (used_d > peak_q) ? used_d : peak_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_CLEAR;
      clr_q   <= '0;
      head_q  <= '0;
      used_q  <= '0;
      peak_q  <= '0;
      total_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      head_q  <= head_d;
      used_q  <= used_d;
      peak_q  <= peak_d;
      total_q <= total_d;
      done_q  <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
    if (emit) begin
      status_q    <= status;
      granted_q   <= granted;
      in_use_q    <= used_d;
      peak_out_q  <= peak_d;
      total_out_q <= total_d;
      full_q      <= (head_d >= SLOT_W'(POOL_DEPTH));
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      next_mem[waddr] <= wdata;
    end
    rd_q <= next_mem[head_q[IDX_W-1:0]];
  end

endmodule

// ===== sv/free_list_pool_allocator_top.sv =====
`timescale 1ns / 1ps
// Pool allocator over a linked free list of equal-sized slots.
// Request channel: start with op_i (0 allocate, 1 free) and offset_i; a word
// is taken on a clock edge where start is high and busy is low.
// Result channel: done_o strobes for one cycle with status_o, granted_offset_o,
// in_use_o, peak_in_use_o, alloc_total_o and full_res_o. The receiver cannot
// stall; every request yields exactly one result word.
// Sequencing: an allocate passes the front end and command FIFO, then the
// back end reads the next free link, or returns at once when the pool is
// exhausted; a free first runs a one-bit-per-cycle remainder divider over the
// 20 offset bits. busy stays high while the front end classifies a request or
// waits on a full command FIFO; the divider sets the free rate.
// Configuration: APB register 0 (address 0) holds element_bytes, clamped to
// 8..1024 in use; write it only while no request is outstanding.
// Reset: the free list link memory is rebuilt one entry a cycle, and busy
// stays high until all 1024 entries are written after rst_ni rises.
module free_list_pool_allocator_top
  import flpa_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic                op_i,
  input  logic [OFF_W-1:0]    offset_i,
  output logic                done_o,
  output logic [STATUS_W-1:0] status_o,
  output logic [OFF_W-1:0]    granted_offset_o,
  output logic [USED_W-1:0]   in_use_o,
  output logic [USED_W-1:0]   peak_in_use_o,
  output logic [TOTAL_W-1:0]  alloc_total_o,
  output logic                full_res_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready
);

  logic [SIZE_W-1:0] elem_bytes_q;
  logic [SIZE_W-1:0] size;
  logic              accept;
  logic              front_idle;
  logic              clearing;
  logic              push;
  logic              pop;
  logic              fifo_full;
  logic              fifo_empty;
  cmd_t              front_cmd;
  cmd_t              back_cmd;

  assign pready = 1'b1;
  assign size   = eff_size(elem_bytes_q);
  assign busy   = !front_idle || clearing;
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elem_bytes_q <= SIZE_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_ELEMENT_BYTES) begin
      elem_bytes_q <= pwdata[SIZE_W-1:0];
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_ELEMENT_BYTES: prdata = DATA_W'(elem_bytes_q);
      default:           prdata = '0;
    endcase
  end

  flpa_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .op_i     (op_i),
    .offset_i (offset_i),
    .size_i   (size),
    .full_i   (fifo_full),
    .push_o   (push),
    .cmd_o    (front_cmd),
    .idle_o   (front_idle)
  );

  flpa_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .pop_i   (pop),
    .cmd_o   (back_cmd),
    .full_o  (fifo_full),
    .empty_o (fifo_empty)
  );

  flpa_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .size_i           (size),
    .empty_i          (fifo_empty),
    .cmd_i            (back_cmd),
    .pop_o            (pop),
    .clearing_o       (clearing),
    .done_o           (done_o),
    .status_o         (status_o),
    .granted_offset_o (granted_offset_o),
    .in_use_o         (in_use_o),
    .peak_in_use_o    (peak_in_use_o),
    .alloc_total_o    (alloc_total_o),
    .full_res_o       (full_res_o)
  );

endmodule
